FILE: rtl/core/csr_batch_edge_merge_top_defines.svh
// ----------------------------------------------------------------------------
// csr batch edge merge assertion macros
// concurrent assertion helpers clocked on clk_i, used by the top level
// ----------------------------------------------------------------------------
`ifndef CSR_BATCH_EDGE_MERGE_TOP_DEFINES_SVH
`define CSR_BATCH_EDGE_MERGE_TOP_DEFINES_SVH

// checked only outside reset
`define CBEM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define CBEM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/cbem_pkg.sv
// ----------------------------------------------------------------------------
// cbem_pkg
// shared types, sizes and codes of the csr batch edge merge block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbem_pkg;

  localparam int MAX_V = 1024;
  localparam int MAX_E = 8192;
  localparam int MAX_N = 4096;

  localparam int VW   = 10;  // vertex id
  localparam int VAW  = 11;  // offset store address, holds MAX_V
  localparam int EAW  = 13;  // edge store address
  localparam int NAW  = 12;  // triplet store address
  localparam int OW   = 14;  // offsets and cursors, hold MAX_E
  localparam int CW   = 13;  // triplet count, holds MAX_N
  localparam int WW   = 32;
  localparam int IDXW = 14;  // loop index

  localparam logic [2:0] ACT_LOAD_OFF  = 3'd0;
  localparam logic [2:0] ACT_LOAD_EDGE = 3'd1;
  localparam logic [2:0] ACT_ADD       = 3'd2;
  localparam logic [2:0] ACT_BUILD     = 3'd3;
  localparam logic [2:0] ACT_RD_OFF    = 3'd4;
  localparam logic [2:0] ACT_RD_EDGE   = 3'd5;

  localparam logic [1:0] KIND_BUILD = 2'd0;
  localparam logic [1:0] KIND_OFF   = 2'd1;
  localparam logic [1:0] KIND_EDGE  = 2'd2;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_REFUSED = 2'd1;
  localparam logic [1:0] STS_DROPPED = 2'd2;
  localparam logic [1:0] STS_RANGE   = 2'd3;

  localparam logic CFG_DIRECTION    = 1'b0;
  localparam logic CFG_NUM_VERTICES = 1'b1;

  typedef struct packed {
    logic [2:0]           action;
    logic [12:0]          position;
    logic [VW-1:0]        first_vertex;
    logic [VW-1:0]        second_vertex;
    logic signed [WW-1:0] weight;
    logic [OW-1:0]        offset_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [OW-1:0]        offset_out;
    logic [VW-1:0]        neighbor_out;
    logic signed [WW-1:0] weight_out;
    logic [1:0]           status;
  } out_item_t;

  typedef struct packed {
    logic [VW-1:0] nb;
    logic [WW-1:0] w;
  } edge_t;

  typedef struct packed {
    logic [VW-1:0] src;
    logic [VW-1:0] dst;
    logic [WW-1:0] w;
  } trip_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RESP, S_C_RD, S_C_US, S_K_RD, S_K_US, S_CLR,
    S_N_RD, S_N_US, S_N_WR, S_P_RD, S_P_US, S_P_END,
    S_S_RD, S_S_US, S_S_WR, S_O_V, S_O_L, S_O_RD, S_O_WR,
    S_X_RD, S_X_WR, S_Y_RD, S_Y_WR, S_FIN_OK, S_FIN_REF
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_RESP, OP_C_RD, OP_C_US, OP_K_RD, OP_K_US, OP_CLR,
    OP_N_RD, OP_N_US, OP_N_WR, OP_P_RD, OP_P_US, OP_P_END,
    OP_S_RD, OP_S_US, OP_S_WR, OP_O_V, OP_O_L, OP_O_RD, OP_O_WR, OP_O_NEXT,
    OP_X_RD, OP_X_WR, OP_Y_RD, OP_Y_WR, OP_FIN_OK, OP_FIN_REF
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   idx_clr;
    logic   idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_eq_nv;
    logic idx_gt_nv;
    logic idx_eq_cnt;
    logic idx_eq_tot;
    logic trip_keep;
    logic chk_bad;
    logic kept_ovf;
    logic e_eq_hi;
    logic out_busy;
  } dp_status_t;

endpackage

FILE: rtl/core/cbem_ctrl.sv
// ----------------------------------------------------------------------------
// cbem_ctrl
// sequencer: item acceptance and the phases of a build
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbem_ctrl
  import cbem_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] action_i,
  input  dp_status_t st_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        take;

  assign in_ready_o = (state_q == S_IDLE) && !st_i.out_busy;
  assign take       = in_ready_o && in_valid_i;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          if (action_i == ACT_BUILD) begin
            state_d = S_C_RD;
          end else if (action_i == ACT_RD_OFF || action_i == ACT_RD_EDGE) begin
            state_d = S_RESP;
          end
        end
      end
      S_RESP:  state_d = S_IDLE;
      S_C_RD:  state_d = S_C_US;
      S_C_US: begin
        if (st_i.chk_bad) begin
          state_d = S_FIN_REF;
        end else if (st_i.idx_eq_nv) begin
          state_d = S_K_RD;
        end else begin
          state_d = S_C_RD;
        end
      end
      S_K_RD: begin
        if (!st_i.idx_eq_cnt) begin
          state_d = S_K_US;
        end else if (st_i.kept_ovf) begin
          state_d = S_FIN_REF;
        end else begin
          state_d = S_CLR;
        end
      end
      S_K_US:  state_d = S_K_RD;
      S_CLR:   state_d = st_i.idx_eq_nv ? S_N_RD : S_CLR;
      S_N_RD:  state_d = st_i.idx_eq_cnt ? S_P_RD : S_N_US;
      S_N_US:  state_d = st_i.trip_keep ? S_N_WR : S_N_RD;
      S_N_WR:  state_d = S_N_RD;
      S_P_RD:  state_d = st_i.idx_eq_nv ? S_P_END : S_P_US;
      S_P_US:  state_d = S_P_RD;
      S_P_END: state_d = S_S_RD;
      S_S_RD:  state_d = st_i.idx_eq_cnt ? S_O_V : S_S_US;
      S_S_US:  state_d = st_i.trip_keep ? S_S_WR : S_S_RD;
      S_S_WR:  state_d = S_S_RD;
      S_O_V:   state_d = st_i.idx_eq_nv ? S_X_RD : S_O_L;
      S_O_L:   state_d = S_O_RD;
      S_O_RD:  state_d = st_i.e_eq_hi ? S_O_V : S_O_WR;
      S_O_WR:  state_d = S_O_RD;
      S_X_RD:  state_d = st_i.idx_eq_tot ? S_Y_RD : S_X_WR;
      S_X_WR:  state_d = S_X_RD;
      S_Y_RD:  state_d = st_i.idx_gt_nv ? S_FIN_OK : S_Y_WR;
      S_Y_WR:  state_d = S_Y_RD;
      S_FIN_OK:  state_d = S_IDLE;
      S_FIN_REF: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.op      = OP_NONE;
    cmd_o.idx_clr = 1'b0;
    cmd_o.idx_inc = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          cmd_o.op      = OP_ACCEPT;
          cmd_o.idx_clr = 1'b1;
        end
      end
      S_RESP: cmd_o.op = OP_RESP;
      S_C_RD: cmd_o.op = OP_C_RD;
      S_C_US: begin
        cmd_o.op      = OP_C_US;
        cmd_o.idx_clr = st_i.idx_eq_nv;
        cmd_o.idx_inc = !st_i.idx_eq_nv;
      end
      S_K_RD: begin
        if (st_i.idx_eq_cnt) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.op = OP_K_RD;
        end
      end
      S_K_US: begin
        cmd_o.op      = OP_K_US;
        cmd_o.idx_inc = 1'b1;
      end
      S_CLR: begin
        if (st_i.idx_eq_nv) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.op      = OP_CLR;
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_N_RD: begin
        if (st_i.idx_eq_cnt) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.op = OP_N_RD;
        end
      end
      S_N_US: begin
        cmd_o.op      = OP_N_US;
        cmd_o.idx_inc = !st_i.trip_keep;
      end
      S_N_WR: begin
        cmd_o.op      = OP_N_WR;
        cmd_o.idx_inc = 1'b1;
      end
      S_P_RD: cmd_o.op = st_i.idx_eq_nv ? OP_NONE : OP_P_RD;
      S_P_US: begin
        cmd_o.op      = OP_P_US;
        cmd_o.idx_inc = 1'b1;
      end
      S_P_END: begin
        cmd_o.op      = OP_P_END;
        cmd_o.idx_clr = 1'b1;
      end
      S_S_RD: begin
        if (st_i.idx_eq_cnt) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.op = OP_S_RD;
        end
      end
      S_S_US: begin
        cmd_o.op      = OP_S_US;
        cmd_o.idx_inc = !st_i.trip_keep;
      end
      S_S_WR: begin
        cmd_o.op      = OP_S_WR;
        cmd_o.idx_inc = 1'b1;
      end
      S_O_V: begin
        if (st_i.idx_eq_nv) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.op = OP_O_V;
        end
      end
      S_O_L: cmd_o.op = OP_O_L;
      S_O_RD: begin
        if (st_i.e_eq_hi) begin
          cmd_o.op      = OP_O_NEXT;
          cmd_o.idx_inc = 1'b1;
        end else begin
          cmd_o.op = OP_O_RD;
        end
      end
      S_O_WR: cmd_o.op = OP_O_WR;
      S_X_RD: begin
        if (st_i.idx_eq_tot) begin
          cmd_o.idx_clr = 1'b1;
        end else begin
          cmd_o.op = OP_X_RD;
        end
      end
      S_X_WR: begin
        cmd_o.op      = OP_X_WR;
        cmd_o.idx_inc = 1'b1;
      end
      S_Y_RD: cmd_o.op = st_i.idx_gt_nv ? OP_NONE : OP_Y_RD;
      S_Y_WR: begin
        cmd_o.op      = OP_Y_WR;
        cmd_o.idx_inc = 1'b1;
      end
      S_FIN_OK:  cmd_o.op = OP_FIN_OK;
      S_FIN_REF: cmd_o.op = OP_FIN_REF;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

FILE: rtl/core/cbem_dp.sv
// ----------------------------------------------------------------------------
// cbem_dp
// graph stores, triplet buffer, build counters and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbem_dp
  import cbem_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  in_item_t   in_data_i,
  input  dp_cmd_t    cmd_i,
  input  logic       out_ready_i,
  output dp_status_t st_o,
  output logic       out_valid_o,
  output out_item_t  out_data_o
);

  // stores
  logic [OW-1:0] offs_mem [MAX_V+1];
  logic [OW-1:0] mofs_mem [MAX_V+1];
  logic [OW-1:0] deg_mem  [MAX_V];
  edge_t         edge_mem [MAX_E];
  edge_t         mrg_mem  [MAX_E];
  trip_t         trip_mem [MAX_N];

  logic           offs_we, offs_re, mofs_we, mofs_re, deg_we, deg_re;
  logic           edge_we, edge_re, mrg_we, mrg_re, trip_we, trip_re;
  logic [VAW-1:0] offs_wa, offs_ra, mofs_wa, mofs_ra;
  logic [VW-1:0]  deg_wa, deg_ra;
  logic [EAW-1:0] edge_wa, edge_ra, mrg_wa, mrg_ra;
  logic [NAW-1:0] trip_wa, trip_ra;
  logic [OW-1:0]  offs_wd, mofs_wd, deg_wd;
  edge_t          edge_wd, mrg_wd;
  trip_t          trip_wd;
  logic [OW-1:0]  offs_rd_q, mofs_rd_q, deg_rd_q;
  edge_t          edge_rd_q, mrg_rd_q;
  trip_t          trip_rd_q;

  // control and working registers
  logic           direction_q;
  logic [10:0]    num_vertices_q;
  logic [CW-1:0]  new_count_q;
  logic           dropped_q;
  logic [IDXW-1:0] idx_q;
  logic [CW-1:0]  kept_q;
  logic [OW-1:0]  sum_q, prev_q, onv_q, tot_q, hi_q, pos_q, ecur_q;
  logic [1:0]     rkind_q;
  logic           roor_q;
  logic           out_valid_q;
  out_item_t      out_q;

  logic [VAW-1:0] nv;
  logic           off_ok, edge_ok, trip_drop;
  logic [VW-1:0]  grp, nbr;
  logic [OW-1:0]  start;

  // effective vertex count
  always_comb begin
    if (num_vertices_q == '0) begin
      nv = VAW'(1);
    end else if (num_vertices_q > VAW'(MAX_V)) begin
      nv = VAW'(MAX_V);
    end else begin
      nv = num_vertices_q;
    end
  end

  assign off_ok    = {1'b0, in_data_i.position} <= OW'(MAX_V);
  assign edge_ok   = {1'b0, in_data_i.position} < OW'(MAX_E);
  assign trip_drop = ({1'b0, in_data_i.first_vertex} >= nv)
                  || ({1'b0, in_data_i.second_vertex} >= nv)
                  || (new_count_q >= CW'(MAX_N));
  assign grp   = direction_q ? trip_rd_q.dst : trip_rd_q.src;
  assign nbr   = direction_q ? trip_rd_q.src : trip_rd_q.dst;
  assign start = sum_q + offs_rd_q;

  // status to the sequencer
  always_comb begin
    st_o.idx_eq_nv  = idx_q == IDXW'(nv);
    st_o.idx_gt_nv  = idx_q > IDXW'(nv);
    st_o.idx_eq_cnt = idx_q == IDXW'(new_count_q);
    st_o.idx_eq_tot = idx_q == IDXW'(tot_q);
    st_o.trip_keep  = ({1'b0, trip_rd_q.src} < nv) && ({1'b0, trip_rd_q.dst} < nv);
    st_o.chk_bad    = ((idx_q == '0) && (offs_rd_q != '0))
                   || ((idx_q != '0) && (offs_rd_q < prev_q))
                   || ((idx_q == IDXW'(nv)) && (offs_rd_q > OW'(MAX_E)));
    st_o.kept_ovf   = {1'b0, kept_q} > (OW'(MAX_E) - onv_q);
    st_o.e_eq_hi    = ecur_q == hi_q;
    st_o.out_busy   = out_valid_q && !out_ready_i;
  end

  // store port selection
  always_comb begin
    offs_we = 1'b0; offs_re = 1'b0; offs_wa = '0; offs_ra = '0; offs_wd = '0;
    mofs_we = 1'b0; mofs_re = 1'b0; mofs_wa = '0; mofs_ra = '0; mofs_wd = '0;
    deg_we  = 1'b0; deg_re  = 1'b0; deg_wa  = '0; deg_ra  = '0; deg_wd  = '0;
    edge_we = 1'b0; edge_re = 1'b0; edge_wa = '0; edge_ra = '0; edge_wd = '0;
    mrg_we  = 1'b0; mrg_re  = 1'b0; mrg_wa  = '0; mrg_ra  = '0; mrg_wd  = '0;
    trip_we = 1'b0; trip_re = 1'b0; trip_wa = '0; trip_ra = '0; trip_wd = '0;
    case (cmd_i.op)
      OP_ACCEPT: begin
        unique case (in_data_i.action)
          ACT_LOAD_OFF: begin
            offs_we = off_ok;
            offs_wa = in_data_i.position[VAW-1:0];
            offs_wd = in_data_i.offset_value;
          end
          ACT_LOAD_EDGE: begin
            edge_we    = edge_ok;
            edge_wa    = in_data_i.position[EAW-1:0];
            edge_wd.nb = in_data_i.first_vertex;
            edge_wd.w  = in_data_i.weight;
          end
          ACT_ADD: begin
            trip_we     = !trip_drop;
            trip_wa     = new_count_q[NAW-1:0];
            trip_wd.src = in_data_i.first_vertex;
            trip_wd.dst = in_data_i.second_vertex;
            trip_wd.w   = in_data_i.weight;
          end
          ACT_RD_OFF: begin
            offs_re = off_ok;
            offs_ra = in_data_i.position[VAW-1:0];
          end
          ACT_RD_EDGE: begin
            edge_re = edge_ok;
            edge_ra = in_data_i.position[EAW-1:0];
          end
          default: ;
        endcase
      end
      OP_C_RD, OP_P_RD: begin
        offs_re = 1'b1;
        offs_ra = idx_q[VAW-1:0];
        deg_re  = cmd_i.op == OP_P_RD;
        deg_ra  = idx_q[VW-1:0];
      end
      OP_K_RD, OP_N_RD, OP_S_RD: begin
        trip_re = 1'b1;
        trip_ra = idx_q[NAW-1:0];
      end
      OP_CLR: begin
        deg_we = 1'b1;
        deg_wa = idx_q[VW-1:0];
      end
      OP_N_US, OP_S_US: begin
        deg_re = st_o.trip_keep;
        deg_ra = grp;
      end
      OP_N_WR: begin
        deg_we = 1'b1;
        deg_wa = grp;
        deg_wd = deg_rd_q + OW'(1);
      end
      OP_P_US: begin
        mofs_we = 1'b1;
        mofs_wa = idx_q[VAW-1:0];
        mofs_wd = start;
        deg_we  = 1'b1;
        deg_wa  = idx_q[VW-1:0];
        deg_wd  = start;
      end
      OP_P_END: begin
        mofs_we = 1'b1;
        mofs_wa = nv;
        mofs_wd = sum_q + onv_q;
      end
      OP_S_WR: begin
        mrg_we    = 1'b1;
        mrg_wa    = deg_rd_q[EAW-1:0];
        mrg_wd.nb = nbr;
        mrg_wd.w  = trip_rd_q.w;
        deg_we    = 1'b1;
        deg_wa    = grp;
        deg_wd    = deg_rd_q + OW'(1);
      end
      OP_O_V: begin
        deg_re  = 1'b1;
        deg_ra  = idx_q[VW-1:0];
        offs_re = 1'b1;
        offs_ra = VAW'(idx_q + IDXW'(1));
      end
      OP_O_RD: begin
        edge_re = 1'b1;
        edge_ra = ecur_q[EAW-1:0];
      end
      OP_O_WR: begin
        mrg_we = 1'b1;
        mrg_wa = pos_q[EAW-1:0];
        mrg_wd = edge_rd_q;
      end
      OP_X_RD: begin
        mrg_re = 1'b1;
        mrg_ra = idx_q[EAW-1:0];
      end
      OP_X_WR: begin
        edge_we = 1'b1;
        edge_wa = idx_q[EAW-1:0];
        edge_wd = mrg_rd_q;
      end
      OP_Y_RD: begin
        mofs_re = 1'b1;
        mofs_ra = idx_q[VAW-1:0];
      end
      OP_Y_WR: begin
        offs_we = 1'b1;
        offs_wa = idx_q[VAW-1:0];
        offs_wd = mofs_rd_q;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (offs_we) offs_mem[offs_wa] <= offs_wd;
    if (offs_re) offs_rd_q <= offs_mem[offs_ra];
    if (mofs_we) mofs_mem[mofs_wa] <= mofs_wd;
    if (mofs_re) mofs_rd_q <= mofs_mem[mofs_ra];
    if (deg_we)  deg_mem[deg_wa] <= deg_wd;
    if (deg_re)  deg_rd_q <= deg_mem[deg_ra];
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    if (edge_re) edge_rd_q <= edge_mem[edge_ra];
    if (mrg_we)  mrg_mem[mrg_wa] <= mrg_wd;
    if (mrg_re)  mrg_rd_q <= mrg_mem[mrg_ra];
    if (trip_we) trip_mem[trip_wa] <= trip_wd;
    if (trip_re) trip_rd_q <= trip_mem[trip_ra];
  end

  // working registers of the build walk and of read transactions
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_ACCEPT: begin
        rkind_q <= (in_data_i.action == ACT_RD_OFF) ? KIND_OFF : KIND_EDGE;
        roor_q  <= (in_data_i.action == ACT_RD_OFF) ? !off_ok : !edge_ok;
        kept_q  <= '0;
        sum_q   <= '0;
      end
      OP_C_US: begin
        prev_q <= offs_rd_q;
        if (st_o.idx_eq_nv) onv_q <= offs_rd_q;
      end
      OP_K_US: if (st_o.trip_keep) kept_q <= kept_q + CW'(1);
      OP_P_US: sum_q <= sum_q + deg_rd_q;
      OP_P_END: begin
        tot_q  <= sum_q + onv_q;
        prev_q <= '0;
      end
      OP_O_L: begin
        pos_q  <= deg_rd_q;
        hi_q   <= offs_rd_q;
        ecur_q <= prev_q;
      end
      OP_O_NEXT: prev_q <= hi_q;
      OP_O_WR: begin
        pos_q  <= pos_q + OW'(1);
        ecur_q <= ecur_q + OW'(1);
      end
      default: ;
    endcase
  end

  // loop index, configuration, buffer fill and sticky drop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q          <= '0;
      direction_q    <= 1'b0;
      num_vertices_q <= 11'(MAX_V);
      new_count_q    <= '0;
      dropped_q      <= 1'b0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IDXW'(1);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DIRECTION:    direction_q    <= cfg_data_i[0];
          CFG_NUM_VERTICES: num_vertices_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_ACCEPT && in_data_i.action == ACT_ADD) begin
        if (trip_drop) begin
          dropped_q <= 1'b1;
        end else begin
          new_count_q <= new_count_q + CW'(1);
        end
      end
      if (cmd_i.op == OP_FIN_OK) begin
        new_count_q <= '0;
        dropped_q   <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_RESP || cmd_i.op == OP_FIN_OK
                 || cmd_i.op == OP_FIN_REF) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_RESP: begin
        out_q.kind         <= rkind_q;
        out_q.status       <= roor_q ? STS_RANGE : STS_OK;
        out_q.offset_out   <= (roor_q || rkind_q != KIND_OFF) ? '0 : offs_rd_q;
        out_q.neighbor_out <= (roor_q || rkind_q != KIND_EDGE) ? '0 : edge_rd_q.nb;
        out_q.weight_out   <= (roor_q || rkind_q != KIND_EDGE) ? '0 : edge_rd_q.w;
      end
      OP_FIN_OK: begin
        out_q.kind         <= KIND_BUILD;
        out_q.status       <= (dropped_q || kept_q != new_count_q) ? STS_DROPPED : STS_OK;
        out_q.offset_out   <= tot_q;
        out_q.neighbor_out <= '0;
        out_q.weight_out   <= '0;
      end
      OP_FIN_REF: begin
        out_q.kind         <= KIND_BUILD;
        out_q.status       <= STS_REFUSED;
        out_q.offset_out   <= '0;
        out_q.neighbor_out <= '0;
        out_q.weight_out   <= '0;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/core/csr_batch_edge_merge_top.sv
// ----------------------------------------------------------------------------
// csr_batch_edge_merge_top
// csr graph store that merges buffered triplet edges into the stored graph
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------
//   in       | input     | in_valid/in_ready   | in_item_t
//   out      | output    | out_valid/out_ready | out_item_t
//   cfg      | input     | cfg_we, no wait     | index, data
//
// loads, adds and unused actions leave the sequencer idle; a read transaction
// holds the input through its response state and its result is registered
// behind the registered read of the store.
// a build walks the stores, and the input is not ready until it ends.
// reset is asynchronous; no clearing pass, the stores hold nothing valid.
// a waiting result stalls the next transaction only until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "csr_batch_edge_merge_top_defines.svh"

module csr_batch_edge_merge_top
  import cbem_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // sequencer
  cbem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_data_i.action),
    .st_i       (st),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // stores and arithmetic
  cbem_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // checks
  `CBEM_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_o, "result during reset")
  `CBEM_ASSERT(a_stall_blocks_input, out_valid_o && !out_ready_i |-> !in_ready_o, "input while stalled")
  `CBEM_ASSERT(a_build_busy, in_valid_i && in_ready_o && in_data_i.action == ACT_BUILD |=> !in_ready_o, "build not busy")
  `CBEM_ASSERT(a_read_answers, in_valid_i && in_ready_o && (in_data_i.action == ACT_RD_OFF || in_data_i.action == ACT_RD_EDGE) |=> ##1 out_valid_o, "read gave no result")

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the csr batch edge merge block: drives loads, triplet
// adds, builds and reads with random bursts and output stalls, predicts every
// result with its own graph model and compares each result field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cbem_pkg::*;

  // graph model and store of expected results
  class merge_scoreboard;
    logic [OW-1:0] offs [MAX_V+1];
    edge_t         gedge [MAX_E];
    bit            gwritten [MAX_E];
    int            written_list [$];
    trip_t         trips [$];
    bit            dropped;
    bit            dir;
    logic [10:0]   nv_reg;
    out_item_t     exp_q [$];
    int            errors;

    function new();
      dir = 1'b0;
      nv_reg = 11'd1024;
      dropped = 1'b0;
      errors = 0;
    endfunction

    function int eff_nv();
      if (nv_reg == 0) return 1;
      if (nv_reg > MAX_V) return MAX_V;
      return nv_reg;
    endfunction

    function void set_config(logic idx, logic [10:0] data);
      if (idx == CFG_DIRECTION) dir = data[0];
      else nv_reg = data;
    endfunction

    function void mark_edge(int p, edge_t e);
      gedge[p] = e;
      if (!gwritten[p]) begin
        gwritten[p] = 1'b1;
        written_list.push_back(p);
      end
    endfunction

    // checks the stored offsets and room for the kept triplets
    function bit refused(output int kept);
      int nv;
      nv = eff_nv();
      kept = 0;
      if (offs[0] != 0) return 1'b1;
      for (int v = 0; v < nv; v++)
        if (offs[v+1] < offs[v]) return 1'b1;
      if (offs[nv] > MAX_E) return 1'b1;
      foreach (trips[i])
        if (trips[i].src < nv && trips[i].dst < nv) kept++;
      return kept > MAX_E - offs[nv];
    endfunction

    // old edge positions that a build would read but were never loaded
    function void unwritten_reads(ref int miss[$]);
      int kept;
      int nv;
      nv = eff_nv();
      if (refused(kept)) return;
      for (int e = 0; e < offs[nv]; e++)
        if (!gwritten[e]) miss.push_back(e);
    endfunction

    // merge of buffered triplets into the stored graph
    function void merge(output logic [1:0] st, output int total);
      int    kept, nv, sum, g, p;
      int    cursor [MAX_V];
      int    moffs [MAX_V+1];
      edge_t medge [MAX_E];
      edge_t ne;
      nv = eff_nv();
      total = 0;
      if (refused(kept)) begin
        st = STS_REFUSED;
        return;
      end
      for (int v = 0; v < MAX_V; v++) cursor[v] = 0;
      foreach (trips[i])
        if (trips[i].src < nv && trips[i].dst < nv)
          cursor[dir ? trips[i].dst : trips[i].src]++;
      sum = 0;
      for (int v = 0; v < nv; v++) begin
        moffs[v] = sum + offs[v];
        sum += cursor[v];
        cursor[v] = moffs[v];
      end
      moffs[nv] = sum + offs[nv];
      // new edges first, in arrival order
      foreach (trips[i])
        if (trips[i].src < nv && trips[i].dst < nv) begin
          g = dir ? trips[i].dst : trips[i].src;
          ne.nb = dir ? trips[i].src : trips[i].dst;
          ne.w = trips[i].w;
          medge[cursor[g]] = ne;
          cursor[g]++;
        end
      // then the old edges of each vertex
      for (int v = 0; v < nv; v++) begin
        p = cursor[v];
        for (int e = offs[v]; e < offs[v+1]; e++) begin
          medge[p] = gedge[e];
          p++;
        end
      end
      total = moffs[nv];
      for (int e = 0; e < total; e++) mark_edge(e, medge[e]);
      for (int v = 0; v <= nv; v++) offs[v] = OW'(moffs[v]);
      if (kept < trips.size()) dropped = 1'b1;
      trips.delete();
      st = dropped ? STS_DROPPED : STS_OK;
      dropped = 1'b0;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      edge_t     e;
      trip_t     t;
      int        nv, total;
      logic [1:0] st;
      nv = eff_nv();
      r = '0;
      case (it.action)
        ACT_LOAD_OFF: if (it.position <= MAX_V) offs[it.position] = it.offset_value;
        ACT_LOAD_EDGE: begin
          e.nb = it.first_vertex;
          e.w = it.weight;
          mark_edge(it.position, e);
        end
        ACT_ADD: begin
          if (it.first_vertex >= nv || it.second_vertex >= nv || trips.size() >= MAX_N)
            dropped = 1'b1;
          else begin
            t.src = it.first_vertex;
            t.dst = it.second_vertex;
            t.w = it.weight;
            trips.push_back(t);
          end
        end
        ACT_BUILD: begin
          merge(st, total);
          r.kind = KIND_BUILD;
          r.offset_out = OW'(total);
          r.status = st;
          exp_q.push_back(r);
        end
        ACT_RD_OFF: begin
          r.kind = KIND_OFF;
          if (it.position <= MAX_V) r.offset_out = offs[it.position];
          else r.status = STS_RANGE;
          exp_q.push_back(r);
        end
        ACT_RD_EDGE: begin
          r.kind = KIND_EDGE;
          r.neighbor_out = gedge[it.position].nb;
          r.weight_out = gedge[it.position].w;
          exp_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t x;
      if (exp_q.size() == 0) begin
        $error("unexpected result kind %0d status %0d", got.kind, got.status);
        errors++;
        return;
      end
      x = exp_q.pop_front();
      if (got.kind !== x.kind) begin
        $error("kind expected %0d actual %0d", x.kind, got.kind);
        errors++;
      end
      if (got.offset_out !== x.offset_out) begin
        $error("offset_out expected %0d actual %0d", x.offset_out, got.offset_out);
        errors++;
      end
      if (got.neighbor_out !== x.neighbor_out) begin
        $error("neighbor_out expected %0d actual %0d", x.neighbor_out, got.neighbor_out);
        errors++;
      end
      if (got.weight_out !== x.weight_out) begin
        $error("weight_out expected %0d actual %0d", x.weight_out, got.weight_out);
        errors++;
      end
      if (got.status !== x.status) begin
        $error("status expected %0d actual %0d", x.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [10:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;

  merge_scoreboard sb;
  int burst_left;
  int item_count;
  int stall_cnt;
  int stall_mode;

  csr_batch_edge_merge_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #1_000_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver stall pattern, changing mode now and then
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (stall_cnt % 16) < 11;
    endcase
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  function automatic in_item_t mk(logic [2:0] act, int pos, int fv, int sv, int w, int ov);
    in_item_t it;
    it.action = act;
    it.position = 13'(pos);
    it.first_vertex = VW'(fv);
    it.second_vertex = VW'(sv);
    it.weight = WW'(w);
    it.offset_value = OW'(ov);
    return it;
  endfunction

  // one input transaction, with bursts and random gaps
  task automatic send(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
    if (it.action <= ACT_RD_EDGE) item_count++;
  endtask

  // hold the sender until every result is back and the block is quiet
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [10:0] data);
    quiesce();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_config(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int rand_w();
    return $urandom();
  endfunction

  function automatic int rand_ov();
    return $urandom_range(0, MAX_E);
  endfunction

  // well-formed graph of nv rows with a few edges each
  task automatic load_graph();
    int nv, acc;
    nv = sb.eff_nv();
    acc = 0;
    for (int v = 0; v <= nv; v++) begin
      send(mk(ACT_LOAD_OFF, v, $urandom_range(0, 1023), $urandom_range(0, 1023), rand_w(),
              acc));
      if (v < nv) acc += (nv > 64) ? ($urandom_range(0, 7) == 0) : $urandom_range(0, 3);
    end
    for (int e = 0; e < acc; e++)
      send(mk(ACT_LOAD_EDGE, e, $urandom_range(0, 1023), $urandom_range(0, 1023), rand_w(),
              rand_ov()));
  endtask

  // build, first loading old edges read unwritten, or a bad offset 0 if over 64
  task automatic do_build();
    int miss[$];
    sb.unwritten_reads(miss);
    if (miss.size() > 64)
      send(mk(ACT_LOAD_OFF, 0, 0, 0, rand_w(), 1));
    else
      foreach (miss[i])
        send(mk(ACT_LOAD_EDGE, miss[i], $urandom_range(0, 1023), 0, rand_w(), rand_ov()));
    send(mk(ACT_BUILD, $urandom_range(0, 8191), $urandom_range(0, 1023),
            $urandom_range(0, 1023), rand_w(), rand_ov()));
  endtask

  task automatic read_edge();
    send(mk(ACT_RD_EDGE, sb.written_list[$urandom_range(0, sb.written_list.size() - 1)],
            $urandom_range(0, 1023), $urandom_range(0, 1023), rand_w(), rand_ov()));
  endtask

  task automatic read_off(int pos);
    send(mk(ACT_RD_OFF, pos, $urandom_range(0, 1023), $urandom_range(0, 1023), rand_w(),
            rand_ov()));
  endtask

  task automatic add(int s, int d);
    send(mk(ACT_ADD, $urandom_range(0, 8191), s, d, rand_w(), rand_ov()));
  endtask

  // triplets with random content, mostly in range, then a build and reads
  task automatic batch();
    int nv, k;
    nv = sb.eff_nv();
    k = $urandom_range(0, 12);
    repeat (k) begin
      if ($urandom_range(0, 6) == 0) add($urandom_range(0, 1023), $urandom_range(0, 1023));
      else add($urandom_range(0, nv - 1), $urandom_range(0, nv - 1));
    end
    do_build();
    repeat ($urandom_range(1, 5)) begin
      read_off($urandom_range(0, (nv + 2 > MAX_V) ? MAX_V : nv + 2));
      read_edge();
    end
  endtask

  task automatic noise();
    logic [2:0] act;
    repeat ($urandom_range(1, 8)) begin
      act = 3'($urandom_range(0, 7));
      case (act)
        ACT_BUILD: do_build();
        ACT_RD_EDGE: read_edge();
        ACT_LOAD_OFF:
          send(mk(act, ($urandom_range(0, 1) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(MAX_V + 1, 8191),
                  $urandom_range(0, 1023), $urandom_range(0, 1023), rand_w(), rand_ov()));
        default:
          send(mk(act, $urandom_range(0, 8191), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), rand_w(), rand_ov()));
      endcase
    end
  endtask

  task automatic new_setting();
    int pick;
    write_cfg(CFG_DIRECTION, 11'($urandom_range(0, 1)));
    pick = $urandom_range(0, 19);
    if (pick == 0) write_cfg(CFG_NUM_VERTICES, 11'd0);
    else if (pick == 1) write_cfg(CFG_NUM_VERTICES, 11'd1);
    else if (pick == 2) write_cfg(CFG_NUM_VERTICES, 11'(MAX_V));
    else if (pick == 3) write_cfg(CFG_NUM_VERTICES, 11'($urandom_range(MAX_V + 1, 2047)));
    else write_cfg(CFG_NUM_VERTICES, 11'($urandom_range(2, 40)));
    if ($urandom_range(0, 4) != 0) load_graph();
  endtask

  // stimulus
  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_DIRECTION;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    burst_left = 0;
    item_count = 0;
    stall_cnt = 0;
    stall_mode = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // clear every offset so that all of them hold known values
    for (int v = 0; v <= MAX_V; v++) send(mk(ACT_LOAD_OFF, v, 0, 0, 0, 0));

    // field extremes, out of range loads and reads, unused actions
    send(mk(ACT_LOAD_EDGE, 8191, 1023, 1023, 32'h8000_0000, MAX_E));
    send(mk(ACT_LOAD_EDGE, 0, 0, 0, 32'h7fff_ffff, 0));
    send(mk(ACT_LOAD_OFF, 8191, 1023, 1023, -1, 16383 & MAX_E));
    read_edge();
    read_off(MAX_V);
    read_off(MAX_V + 1);
    read_off(8191);
    send(mk(3'd6, 8191, 1023, 1023, -1, MAX_E));
    send(mk(3'd7, 0, 0, 0, 0, 0));
    // plain merge at the widest vertex range
    add(0, 1);
    add(1023, 1023);
    do_build();
    read_off(MAX_V);
    send(mk(ACT_RD_EDGE, 1, 0, 0, 0, 0));

    // bad triplet: vertex outside the graph in use
    write_cfg(CFG_NUM_VERTICES, 11'd2);
    add(5, 0);
    do_build();
    // build overflow: stored offsets already fill the edge store
    send(mk(ACT_LOAD_OFF, 1, 0, 0, 0, MAX_E));
    send(mk(ACT_LOAD_OFF, 2, 0, 0, 0, MAX_E));
    add(0, 1);
    do_build();
    // malformed offsets: first offset not zero, then decreasing
    send(mk(ACT_LOAD_OFF, 0, 0, 0, 0, 1));
    do_build();
    send(mk(ACT_LOAD_OFF, 0, 0, 0, 0, 0));
    send(mk(ACT_LOAD_OFF, 2, 0, 0, 0, 0));
    do_build();
    send(mk(ACT_LOAD_OFF, 1, 0, 0, 0, 0));

    // stale triplet: vertex range lowered after the add
    write_cfg(CFG_DIRECTION, 11'd1);
    write_cfg(CFG_NUM_VERTICES, 11'(MAX_V));
    add(500, 3);
    add(1, 0);
    write_cfg(CFG_NUM_VERTICES, 11'd2);
    do_build();
    read_edge();

    // full triplet buffer: the extra one is dropped
    write_cfg(CFG_DIRECTION, 11'd0);
    load_graph();
    repeat (MAX_N + 1) add($urandom_range(0, 1), $urandom_range(0, 1));
    do_build();
    read_off(2);
    load_graph();

    // random part
    while (item_count < 1400 + MAX_N + MAX_V) begin
      case ($urandom_range(0, 9))
        0: new_setting();
        1: load_graph();
        2, 3: noise();
        default: batch();
      endcase
    end

    quiesce();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
